@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/ffpa_pkg.sv @@
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types and constants of the first-fit page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ffpa_pkg;

  localparam int ADDR_W     = 48;
  localparam int SIZE_W     = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int PAGE_BYTES = 4096;
  // page count of a 32-bit byte size, rounded up
  localparam int PCNT_W     = SIZE_W - PAGE_SHIFT + 1;
  // page index of a 48-bit address
  localparam int PIDX_W     = ADDR_W - PAGE_SHIFT;
  localparam int WORD_BITS  = 64;
  localparam int WBIT_W     = 6;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef enum logic [0:0] {
    CFG_UNIT_ENABLED = 1'b0,
    CFG_WINDOW_BASE  = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic              mode;
    logic [SIZE_W-1:0] size_bytes;
    logic [ADDR_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] granted_address;
    logic              granted;
  } out_item_t;

endpackage

`default_nettype wire

@@ design/iova_first_fit_page_allocator.sv @@
// ----------------------------------------------------------------------------
// iova_first_fit_page_allocator
// First-fit allocator over a used-page bitmap of a device address window.
// ----------------------------------------------------------------------------
// Channels: in_* carries one request item (allocate or free), out_* returns
// exactly one result item per request, cfg_* writes unit_enabled (index 0)
// and window_base (index 1); cfg_ready is always high.
// The bitmap sits in a memory of 64-bit words, read and written one word a
// cycle. One request is worked at a time; in_ready is high only when idle.
// Allocate: a first-fit scan over the bitmap words, then a read-modify-write
// of each bitmap word of the granted run. Free: range checks, then a
// read-modify-write of each bitmap word cleared. Rejected requests finish
// without a bitmap update.
// Reset: a clearing pass writes every bitmap word (64 at the default window)
// to zero while in_ready stays low; configuration writes are taken
// throughout.
// A stalled receiver holds the result in the output register; the next item
// is accepted meanwhile and waits at its last step until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module iova_first_fit_page_allocator
  import ffpa_pkg::*;
#(
  parameter int WINDOW_PAGES = 4096
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output out_item_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire cfg_idx_t          cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data
);

  localparam int NWORDS    = (WINDOW_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int PIW       = AW + WBIT_W;
  localparam int LAST_BITS = WINDOW_PAGES - (NWORDS - 1) * WORD_BITS;
  localparam logic [AW-1:0] LAST_W = AW'(NWORDS - 1);
  localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};
  // pages past the window end in the last word always look used
  localparam logic [WORD_BITS-1:0] PAD_MASK = ~(ONES >> (WORD_BITS - LAST_BITS));

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CHECK, ST_SCAN, ST_START, ST_F_BASE, ST_F_RANGE,
    ST_RMW_PRE, ST_RMW, ST_FIN
  } state_t;

  state_t               state_r;
  logic [AW-1:0]        clr_idx_r;
  logic                 en_r;
  logic [ADDR_W-1:0]    base_r;
  logic                 mode_r;
  logic [PCNT_W-1:0]    pcnt_r;
  logic [ADDR_W-1:0]    faddr_r;
  logic [PIDX_W-1:0]    fstart_r;
  logic [AW-1:0]        widx_r;
  logic [PCNT_W-1:0]    run_r;
  logic [PIW-1:0]       s_pg_r;
  logic [PIW-1:0]       e_pg_r;
  logic [AW-1:0]        k_r;
  logic                 chg_r;
  logic                 ok_r;
  logic [ADDR_W-1:0]    addr_r;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  logic [WORD_BITS-1:0] map_mem [NWORDS];
  logic [WORD_BITS-1:0] rd_data_r;
  logic [AW-1:0]        mem_ra;
  logic                 mem_we;
  logic [AW-1:0]        mem_wa;
  logic [WORD_BITS-1:0] mem_wd;

  // --------------------------------------------------------------------------
  // Request page count
  // --------------------------------------------------------------------------
  logic [SIZE_W:0]      size_sum;
  logic [PCNT_W-1:0]    in_pcnt;

  assign size_sum = {1'b0, in_data.size_bytes} + (SIZE_W + 1)'(PAGE_BYTES - 1);
  assign in_pcnt  = size_sum[SIZE_W:PAGE_SHIFT];

  // --------------------------------------------------------------------------
  // Scan word evaluation
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] scan_u;
  logic [WORD_BITS-1:0] top_mask;
  logic [PCNT_W-1:0]    need;
  logic [PCNT_W-1:0]    need_m1;
  logic [WORD_BITS-1:0] need_therm;
  logic [WORD_BITS-1:0] hit_vec;
  logic                 hit_any;
  logic [WBIT_W-1:0]    hit_pos;
  logic [WBIT_W:0]      lead_free;
  logic [PCNT_W-1:0]    run_nxt;

  assign scan_u   = rd_data_r | ((widx_r == LAST_W) ? PAD_MASK : '0);
  assign top_mask = (pcnt_r >= PCNT_W'(WORD_BITS)) ? ONES : ~(ONES >> pcnt_r[WBIT_W-1:0]);
  assign need     = pcnt_r - run_r;
  assign need_m1  = need - PCNT_W'(1);
  assign need_therm = (need <= PCNT_W'(WORD_BITS)) ? (ONES << need_m1[WBIT_W-1:0]) : '0;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      // run lies wholly inside this word, or continues the carried-in run
      hit_vec[j] = ((PCNT_W'(j + 1) >= pcnt_r) &&
                    (((scan_u << (WORD_BITS - 1 - j)) & top_mask) == '0)) ||
                   (((scan_u & (ONES >> (WORD_BITS - 1 - j))) == '0) && need_therm[j]);
    end
  end

  assign hit_any = |hit_vec;

  always_comb begin
    hit_pos = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit_vec[j]) begin
        hit_pos = WBIT_W'(j);
      end
    end
  end

  always_comb begin
    lead_free = (WBIT_W + 1)'(WORD_BITS);
    for (int j = 0; j < WORD_BITS; j++) begin
      if (scan_u[j]) begin
        lead_free = (WBIT_W + 1)'(WORD_BITS - 1 - j);
      end
    end
  end

  assign run_nxt = (scan_u == '0) ? (run_r + PCNT_W'(WORD_BITS)) : PCNT_W'(lead_free);

  // --------------------------------------------------------------------------
  // Read-modify-write word mask
  // --------------------------------------------------------------------------
  logic [WBIT_W-1:0]    rmw_lo;
  logic [WBIT_W-1:0]    rmw_hi;
  logic [WORD_BITS-1:0] rmw_mask;
  logic                 rmw_last;

  assign rmw_last = (k_r == e_pg_r[PIW-1:WBIT_W]);
  assign rmw_lo   = (k_r == s_pg_r[PIW-1:WBIT_W]) ? s_pg_r[WBIT_W-1:0] : '0;
  assign rmw_hi   = rmw_last ? e_pg_r[WBIT_W-1:0] : WBIT_W'(WORD_BITS - 1);
  assign rmw_mask = (ONES << rmw_lo) & (ONES >> (WBIT_W'(WORD_BITS - 1) - rmw_hi));

  // --------------------------------------------------------------------------
  // Free range arithmetic
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0]    f_off;
  logic [PIDX_W:0]      f_end_sum;
  logic [PIW-1:0]       f_end;

  assign f_off     = faddr_r - base_r;
  assign f_end_sum = {1'b0, fstart_r} + (PIDX_W + 1)'(pcnt_r) - (PIDX_W + 1)'(1);
  assign f_end     = (f_end_sum >= (PIDX_W + 1)'(WINDOW_PAGES - 1)) ?
                     PIW'(WINDOW_PAGES - 1) : f_end_sum[PIW-1:0];

  // --------------------------------------------------------------------------
  // Memory port control
  // --------------------------------------------------------------------------
  always_comb begin
    mem_ra = '0;
    mem_we = 1'b0;
    mem_wa = k_r;
    mem_wd = (mode_r == MODE_ALLOC) ? (rd_data_r | rmw_mask) : (rd_data_r & ~rmw_mask);
    case (state_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx_r;
        mem_wd = '0;
      end
      ST_SCAN: begin
        mem_ra = (widx_r == LAST_W) ? widx_r : widx_r + AW'(1);
      end
      ST_RMW_PRE: begin
        mem_ra = s_pg_r[PIW-1:WBIT_W];
      end
      ST_RMW: begin
        mem_we = 1'b1;
        mem_ra = rmw_last ? k_r : k_r + AW'(1);
      end
      default: begin
        mem_ra = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      map_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= map_mem[mem_ra];
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      en_r        <= 1'b0;
      base_r      <= ADDR_W'(48'h0000_1000_0000);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_UNIT_ENABLED: en_r   <= cfg_data[0];
          CFG_WINDOW_BASE:  base_r <= cfg_data;
          default:          en_r   <= en_r;
        endcase
      end

      // the final step reloads the register itself
      if (out_valid_r && out_ready && state_r != ST_FIN) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_CLEAR: begin
          clr_idx_r <= clr_idx_r + AW'(1);
          if (clr_idx_r == LAST_W) begin
            state_r <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            mode_r  <= in_data.mode;
            faddr_r <= in_data.free_address;
            pcnt_r  <= in_pcnt;
            chg_r   <= 1'b0;
            state_r <= (in_data.mode == MODE_ALLOC) ? ST_CHECK : ST_F_BASE;
          end
        end
        ST_CHECK: begin
          widx_r <= '0;
          run_r  <= '0;
          if (!en_r || pcnt_r == '0 || pcnt_r > PCNT_W'(WINDOW_PAGES)) begin
            ok_r    <= 1'b0;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (hit_any) begin
            e_pg_r  <= {widx_r, hit_pos};
            state_r <= ST_START;
          end else if (widx_r == LAST_W) begin
            ok_r    <= 1'b0;
            state_r <= ST_FIN;
          end else begin
            widx_r <= widx_r + AW'(1);
            run_r  <= run_nxt;
          end
        end
        ST_START: begin
          s_pg_r  <= e_pg_r + PIW'(1) - pcnt_r[PIW-1:0];
          state_r <= ST_RMW_PRE;
        end
        ST_F_BASE: begin
          fstart_r <= f_off[ADDR_W-1:PAGE_SHIFT];
          if (!en_r || faddr_r < base_r) begin
            ok_r    <= 1'b0;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_F_RANGE;
          end
        end
        ST_F_RANGE: begin
          s_pg_r <= fstart_r[PIW-1:0];
          e_pg_r <= f_end;
          if (pcnt_r == '0 || fstart_r >= PIDX_W'(WINDOW_PAGES)) begin
            ok_r    <= 1'b0;
            state_r <= ST_FIN;
          end else begin
            state_r <= ST_RMW_PRE;
          end
        end
        ST_RMW_PRE: begin
          addr_r  <= base_r + (ADDR_W'(s_pg_r) << PAGE_SHIFT);
          k_r     <= s_pg_r[PIW-1:WBIT_W];
          state_r <= ST_RMW;
        end
        ST_RMW: begin
          chg_r <= chg_r | ((rd_data_r & rmw_mask) != '0);
          if (rmw_last) begin
            ok_r    <= (mode_r == MODE_ALLOC) | chg_r | ((rd_data_r & rmw_mask) != '0);
            state_r <= ST_FIN;
          end else begin
            k_r <= k_r + AW'(1);
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid_r || out_ready) begin
            out_valid_r                <= 1'b1;
            out_data_r.granted         <= ok_r;
            out_data_r.granted_address <= (ok_r && mode_r == MODE_ALLOC) ? addr_r : '0;
            state_r                    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "item accepted while busy")
  `ASSERT_IMP(a_fail_zero, out_valid && !out_data.granted, out_data.granted_address == '0, "failed result carries an address")
  `ASSERT_IMP(a_rmw_range, state_r == ST_RMW, k_r <= e_pg_r[PIW-1:WBIT_W] && k_r >= s_pg_r[PIW-1:WBIT_W], "word update outside run")
  `ASSERT_IMP(a_clear_busy, state_r == ST_CLEAR, !out_valid_r && !in_ready, "activity during bitmap clear")

endmodule

`default_nettype wire
